// ===== design/prau_pkg.sv =====
package prau_pkg;

  localparam int RowW         = 32;
  localparam int GridWidthDef = 32;

  // configuration port
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 2;
  localparam logic [CfgIdxW-1:0] CFG_NEIGHBOURHOOD_MODE = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_INCLUDE_SELF       = 1'd1;

  // output queue
  localparam int OqDepth = 4;
  localparam int OqPtrW  = 2;
  localparam int OqCntW  = 3;

  typedef enum logic [1:0] {
    MODE_MOORE       = 2'd0,
    MODE_VON_NEUMANN = 2'd1,
    MODE_DIAGONAL    = 2'd2
  } mode_e;

  typedef struct packed {
    logic [1:0] mode;
    logic       include_self;
  } rule_cfg_t;

  // 3x3 window around one cell, bit 0 = column to the left
  typedef struct packed {
    logic [2:0] up;
    logic [2:0] mid;
    logic [2:0] dn;
  } lane_win_t;

  typedef struct packed {
    logic [RowW-1:0] cells;
    logic            frame_end;
  } out_beat_t;

endpackage

// ===== design/prau_lane.sv =====
module prau_lane (
  input  prau_pkg::lane_win_t win_i,
  input  prau_pkg::rule_cfg_t cfg_i,
  output logic                cell_o
);

  logic orth;
  logic diag;
  logic par;

  assign orth = win_i.up[1] ^ win_i.dn[1] ^ win_i.mid[0] ^ win_i.mid[2];
  assign diag = win_i.up[0] ^ win_i.up[2] ^ win_i.dn[0] ^ win_i.dn[2];

  always_comb begin
    case (cfg_i.mode)
      prau_pkg::MODE_VON_NEUMANN: par = orth;
      prau_pkg::MODE_DIAGONAL:    par = diag;
      default:                    par = orth ^ diag;  // Moore, and the unused code
    endcase
  end

  assign cell_o = par ^ (cfg_i.include_self & win_i.mid[1]);

endmodule

// ===== design/prau_row.sv =====
module prau_row #(
  parameter int GRID_WIDTH = prau_pkg::GridWidthDef
) (
  input  logic [prau_pkg::RowW-1:0] up_i,
  input  logic [prau_pkg::RowW-1:0] mid_i,
  input  logic [prau_pkg::RowW-1:0] dn_i,
  input  prau_pkg::rule_cfg_t       cfg_i,
  output logic [prau_pkg::RowW-1:0] row_o
);

  localparam int Lanes = (GRID_WIDTH > prau_pkg::RowW) ? prau_pkg::RowW : GRID_WIDTH;
  localparam logic [prau_pkg::RowW:0] GridMaskW =
      (prau_pkg::RowW+1)'((64'd1 << Lanes) - 64'd1);
  localparam logic [prau_pkg::RowW-1:0] GridMask = GridMaskW[prau_pkg::RowW-1:0];

  // padded with a dead column on each side
  logic [prau_pkg::RowW+1:0] up_ext;
  logic [prau_pkg::RowW+1:0] mid_ext;
  logic [prau_pkg::RowW+1:0] dn_ext;

  assign up_ext  = {1'b0, up_i  & GridMask, 1'b0};
  assign mid_ext = {1'b0, mid_i & GridMask, 1'b0};
  assign dn_ext  = {1'b0, dn_i  & GridMask, 1'b0};

  for (genvar i = 0; i < prau_pkg::RowW; i++) begin : g_col
    if (i < Lanes) begin : g_lane
      prau_pkg::lane_win_t win;
      assign win.up  = up_ext[i+2:i];
      assign win.mid = mid_ext[i+2:i];
      assign win.dn  = dn_ext[i+2:i];
      prau_lane u_lane (
        .win_i  (win),
        .cfg_i  (cfg_i),
        .cell_o (row_o[i])
      );
    end else begin : g_dead
      assign row_o[i] = 1'b0;
    end
  end

endmodule

// ===== design/prau_outq.sv =====
module prau_outq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [1:0]           push_n_i,
  input  prau_pkg::out_beat_t  beat0_i,
  input  prau_pkg::out_beat_t  beat1_i,
  output logic                 room_o,
  output logic                 valid_o,
  output prau_pkg::out_beat_t  beat_o,
  input  logic                 stall_i
);

  prau_pkg::out_beat_t mem [prau_pkg::OqDepth];

  logic [prau_pkg::OqPtrW-1:0] wr_q, wr_d;
  logic [prau_pkg::OqPtrW-1:0] rd_q, rd_d;
  logic [prau_pkg::OqCntW-1:0] cnt_q, cnt_d;
  logic                        pop;

  assign valid_o = (cnt_q != '0);
  assign beat_o  = mem[rd_q];
  assign pop     = valid_o & ~stall_i;
  // room for the two beats a final row can produce
  assign room_o  = (cnt_q <= prau_pkg::OqCntW'(prau_pkg::OqDepth - 2));

  assign wr_d  = wr_q + prau_pkg::OqPtrW'(push_n_i);
  assign rd_d  = rd_q + prau_pkg::OqPtrW'(pop);
  assign cnt_d = cnt_q + prau_pkg::OqCntW'(push_n_i) - prau_pkg::OqCntW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem[wr_q] <= beat0_i;
    end
    if (push_n_i == 2'd2) begin
      mem[wr_q + 1'b1] <= beat1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== design/parity_rule_automaton_row_step.sv =====
// Parity-rule automaton, one generation, streamed a row per beat.
// Input channel: row_cells_i/final_row_i under in_valid_i/in_stall_o, rows
// top to bottom; final_row_i marks the bottom row of the grid.
// Output channel: next_row_cells_o/frame_end_o under out_valid_o/out_stall_i.
// Each output row is the next generation of the row accepted one beat
// earlier, so the first row of a grid gives nothing; the final row gives two
// beats (the row before it and itself, the latter with frame_end_o set). A
// one-row grid gives one beat with frame_end_o set.
// A result is written into the output queue at the clock edge that accepts the
// beat that completes its window. Throughput: one input row per cycle while
// in_stall_o is low; one lane per grid column evaluates the whole row
// combinationally, so the output port (one beat per cycle) is the only limit.
// A 4-entry output queue decouples the sides; input stalls only while fewer
// than two entries are free, i.e. when the receiver holds out_stall_i.
// Reset empties the line buffers and queue, mode Moore, self not counted.
// The user writes configuration (cfg_we_i/cfg_idx_i/cfg_data_i) only while idle; the block does not enforce this.
module parity_rule_automaton_row_step #(
  parameter int GRID_WIDTH = prau_pkg::GridWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [prau_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [prau_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [prau_pkg::RowW-1:0]     row_cells_i,
  input  logic                          final_row_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [prau_pkg::RowW-1:0]     next_row_cells_o,
  output logic                          frame_end_o
);

  prau_pkg::rule_cfg_t cfg_q;

  logic [prau_pkg::RowW-1:0] row_above_q, row_above_d;
  logic [prau_pkg::RowW-1:0] row_middle_q, row_middle_d;
  logic [1:0]                rows_buf_q, rows_buf_d;

  logic                      accept;
  logic                      room;
  logic                      empty;
  logic [1:0]                push_n;
  logic [prau_pkg::RowW-1:0] a_up, a_mid, a_dn;
  logic [prau_pkg::RowW-1:0] row_a, row_b;
  prau_pkg::out_beat_t       beat0, beat1, beat_out;

  assign in_stall_o = ~room;
  assign accept     = in_valid_i & room;
  assign empty      = (rows_buf_q == 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode         <= prau_pkg::MODE_MOORE;
      cfg_q.include_self <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        prau_pkg::CFG_NEIGHBOURHOOD_MODE: cfg_q.mode         <= cfg_data_i;
        prau_pkg::CFG_INCLUDE_SELF:       cfg_q.include_self <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // first unit: row above the new one (or the lone row of a one-row grid)
  always_comb begin
    if (empty) begin
      a_up  = '0;
      a_mid = row_cells_i;
      a_dn  = '0;
    end else begin
      a_up  = (rows_buf_q == 2'd2) ? row_above_q : '0;
      a_mid = row_middle_q;
      a_dn  = row_cells_i;
    end
  end

  prau_row #(.GRID_WIDTH(GRID_WIDTH)) u_row_a (
    .up_i  (a_up),
    .mid_i (a_mid),
    .dn_i  (a_dn),
    .cfg_i (cfg_q),
    .row_o (row_a)
  );

  // second unit: the bottom row itself, on a final beat
  prau_row #(.GRID_WIDTH(GRID_WIDTH)) u_row_b (
    .up_i  (row_middle_q),
    .mid_i (row_cells_i),
    .dn_i  ('0),
    .cfg_i (cfg_q),
    .row_o (row_b)
  );

  assign beat0.cells     = row_a;
  assign beat0.frame_end = empty & final_row_i;
  assign beat1.cells     = row_b;
  assign beat1.frame_end = 1'b1;

  always_comb begin
    push_n       = 2'd0;
    row_above_d  = row_above_q;
    row_middle_d = row_middle_q;
    rows_buf_d   = rows_buf_q;
    if (accept) begin
      if (empty) begin
        if (final_row_i) begin
          push_n = 2'd1;
        end else begin
          row_above_d  = '0;
          row_middle_d = row_cells_i;
          rows_buf_d   = 2'd1;
        end
      end else if (final_row_i) begin
        push_n       = 2'd2;
        row_above_d  = '0;
        row_middle_d = '0;
        rows_buf_d   = 2'd0;
      end else begin
        push_n       = 2'd1;
        row_above_d  = row_middle_q;
        row_middle_d = row_cells_i;
        rows_buf_d   = 2'd2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_above_q  <= '0;
      row_middle_q <= '0;
      rows_buf_q   <= 2'd0;
    end else begin
      row_above_q  <= row_above_d;
      row_middle_q <= row_middle_d;
      rows_buf_q   <= rows_buf_d;
    end
  end

  prau_outq u_outq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .beat0_i  (beat0),
    .beat1_i  (beat1),
    .room_o   (room),
    .valid_o  (out_valid_o),
    .beat_o   (beat_out),
    .stall_i  (out_stall_i)
  );

  assign next_row_cells_o = beat_out.cells;
  assign frame_end_o      = beat_out.frame_end;

endmodule

// ===== tb/sv/parity_rule_automaton_row_step_tb.sv =====
module parity_rule_automaton_row_step_tb;

  localparam int QuietLimit = 2000;
  localparam int PhaseRows  = 168;

  class parity_scoreboard;
    logic [1:0]                mode;
    logic                      self_on;
    logic [prau_pkg::RowW-1:0] above;
    logic [prau_pkg::RowW-1:0] middle;
    int unsigned               held;
    prau_pkg::out_beat_t       due_q[$];
    int unsigned               errors;

    function new();
      mode    = prau_pkg::MODE_MOORE;
      self_on = 1'b0;
      above   = '0;
      middle  = '0;
      held    = 0;
      errors  = 0;
    endfunction

    // data bits above a register's width are dropped
    function void write_reg(logic [prau_pkg::CfgIdxW-1:0] idx,
                            logic [prau_pkg::CfgDataW-1:0] data);
      if (idx == prau_pkg::CFG_NEIGHBOURHOOD_MODE) begin
        mode = data;
      end else if (idx == prau_pkg::CFG_INCLUDE_SELF) begin
        self_on = data[0];
      end
    endfunction

    // shifts at row width drop the columns outside the grid
    function logic [prau_pkg::RowW-1:0] evolve(logic [prau_pkg::RowW-1:0] up,
                                               logic [prau_pkg::RowW-1:0] mid,
                                               logic [prau_pkg::RowW-1:0] dn);
      logic [prau_pkg::RowW-1:0] orth;
      logic [prau_pkg::RowW-1:0] diag;
      logic [prau_pkg::RowW-1:0] r;
      orth = up ^ dn ^ (mid << 1) ^ (mid >> 1);
      diag = (up << 1) ^ (up >> 1) ^ (dn << 1) ^ (dn >> 1);
      case (mode)
        prau_pkg::MODE_VON_NEUMANN: r = orth;
        prau_pkg::MODE_DIAGONAL:    r = diag;
        default:                    r = orth ^ diag;  // mode 3 falls back to Moore
      endcase
      if (self_on) r = r ^ mid;
      return r;
    endfunction

    function void note_row(logic [prau_pkg::RowW-1:0] cells, logic last);
      prau_pkg::out_beat_t b;
      if (held == 0) begin
        if (last) begin
          b.cells     = evolve('0, cells, '0);
          b.frame_end = 1'b1;
          due_q       = {due_q, b};
        end else begin
          above  = '0;
          middle = cells;
          held   = 1;
        end
      end else begin
        b.cells     = evolve((held >= 2) ? above : '0, middle, cells);
        b.frame_end = 1'b0;
        due_q       = {due_q, b};
        if (last) begin
          b.cells     = evolve(middle, cells, '0);
          b.frame_end = 1'b1;
          due_q       = {due_q, b};
          above  = '0;
          middle = '0;
          held   = 0;
        end else begin
          above  = middle;
          middle = cells;
          held   = 2;
        end
      end
    endfunction

    function void check_beat(logic [prau_pkg::RowW-1:0] cells, logic fe);
      prau_pkg::out_beat_t want;
      if (due_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, got cells=%h frame_end=%b",
                 $time, cells, fe);
      end else begin
        want = due_q.pop_front();
        if (want.cells !== cells) begin
          errors++;
          $display("%0t: next_row_cells expected %h got %h", $time, want.cells, cells);
        end
        if (want.frame_end !== fe) begin
          errors++;
          $display("%0t: frame_end expected %b got %b", $time, want.frame_end, fe);
        end
      end
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [prau_pkg::CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [prau_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic [prau_pkg::RowW-1:0]     row_cells_i = '0;
  logic                          final_row_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [prau_pkg::RowW-1:0]     next_row_cells_o;
  logic                          frame_end_o;

  parity_scoreboard sb;
  int unsigned      gap_pct = 0;
  int unsigned      stall_pct = 0;
  int unsigned      quiet_cycles = 0;

  parity_rule_automaton_row_step dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .row_cells_i      (row_cells_i),
    .final_row_i      (final_row_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .next_row_cells_o (next_row_cells_o),
    .frame_end_o      (frame_end_o)
  );

  always #4 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) sb.note_row(row_cells_i, final_row_i);
    if (out_valid_o && !out_stall_i) sb.check_beat(next_row_cells_o, frame_end_o);
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("parity_rule_automaton_row_step regression: fail");
      $finish;
    end
  end

  task automatic send_row(input logic [prau_pkg::RowW-1:0] cells, input logic last);
    @(negedge clk_i);
    while ((gap_pct != 0) && ($urandom_range(99) < gap_pct)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    row_cells_i <= cells;
    final_row_i <= last;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic write_cfg(input logic [prau_pkg::CfgIdxW-1:0] idx,
                           input logic [prau_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  // drop valid, wait for every expected beat, then add idle slack
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [prau_pkg::RowW-1:0] rand_row();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return 32'h1 << $urandom_range(prau_pkg::RowW - 1);
      3:       return $urandom & $urandom;
      4:       return $urandom | $urandom;
      5:       return 32'h8000_0001 | ($urandom & $urandom & $urandom);
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned frame_rows();
    if ($urandom_range(9) == 0) return $urandom_range(40, 13);
    return $urandom_range(8, 1);
  endfunction

  initial begin
    int unsigned rows_left;
    sb = new();
    rows_left = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // one-row grids, then short grids with edge columns and dense patterns
    send_row(32'hFFFF_FFFF, 1'b1);
    send_row(32'h0000_0000, 1'b1);
    send_row(32'h8000_0001, 1'b1);
    send_row(32'h0000_0001, 1'b0);
    send_row(32'h8000_0000, 1'b1);
    send_row(32'hFFFF_FFFF, 1'b0);
    send_row(32'h0000_0000, 1'b0);
    send_row(32'hFFFF_FFFF, 1'b1);
    send_row(32'h5555_5555, 1'b0);
    send_row(32'hAAAA_AAAA, 1'b0);
    send_row(32'h0001_0000, 1'b0);
    send_row(32'hC000_0003, 1'b0);
    send_row(32'hFFFF_FFFF, 1'b1);

    for (int p = 0; p < 8; p++) begin
      drain();
      write_cfg(prau_pkg::CFG_NEIGHBOURHOOD_MODE, prau_pkg::CfgDataW'((p + 1) % 4));
      // include_self data walks 0..3 so the upper data bit is exercised
      write_cfg(prau_pkg::CFG_INCLUDE_SELF, prau_pkg::CfgDataW'((p + p / 4) % 4));
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 46; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 46; end
        default: begin gap_pct = 32; stall_pct = 32; end
      endcase
      for (int i = 0; i < PhaseRows; i++) begin
        if (rows_left == 0) rows_left = frame_rows();
        rows_left--;
        // close the grid at the end of a phase so no row is held over a config write
        if (i == PhaseRows - 1) rows_left = 0;
        send_row(rand_row(), rows_left == 0);
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("parity_rule_automaton_row_step regression: pass");
    end else begin
      $display("parity_rule_automaton_row_step regression: fail");
    end
    $finish;
  end

endmodule
